[design/fixed_point_alu_top_macros.svh]
// assertion macros shared by the checker
`ifndef FIXED_POINT_ALU_TOP_MACROS_SVH
`define FIXED_POINT_ALU_TOP_MACROS_SVH

// checked only outside reset
`define FPA_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) expr) else $error(msg);

// checked at every edge, reset included
`define FPA_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) expr) else $error(msg);

`endif

[design/fpa_pkg.sv]
package fpa_pkg;

   localparam int FRAC_BITS     = 8;
   localparam int WORD_BITS     = 32;
   localparam int OPER_BITS     = 32;
   localparam int SAT_BITS      = (WORD_BITS < OPER_BITS) ? WORD_BITS : OPER_BITS;
   localparam int NUM_BITS      = OPER_BITS + FRAC_BITS;
   localparam int PROD_BITS     = 2 * OPER_BITS;
   localparam int WIDE_BITS     = PROD_BITS + 2;
   localparam int MODE_BITS     = 4;
   localparam int REQ_DATA_BITS = 2 * OPER_BITS;
   localparam int RSP_DATA_BITS = ((OPER_BITS + 5 + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - OPER_BITS - 5;

   localparam logic signed [WIDE_BITS-1:0] ONE_W = WIDE_BITS'(1);
   localparam logic [PROD_BITS-1:0] HALF_LSB = PROD_BITS'(1) << (FRAC_BITS - 1);

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD = 4'd0,
      MODE_SUB = 4'd1,
      MODE_MUL = 4'd2,
      MODE_DIV = 4'd3,
      MODE_MIN = 4'd4,
      MODE_MAX = 4'd5,
      MODE_INC = 4'd6,
      MODE_DEC = 4'd7,
      MODE_I2F = 4'd8,
      MODE_F2I = 4'd9
   } mode_type;

   // per-item payload that rides along the divider row
   typedef struct packed {
      logic [MODE_BITS-1:0]        mode;
      logic [OPER_BITS-1:0]        pre_res;
      logic                        pre_ovf;
      logic                        lt;
      logic                        gt;
      logic                        eq;
      logic                        dz;
      logic signed [PROD_BITS-1:0] prod;
      logic                        neg;
      logic [OPER_BITS-1:0]        dsr;
   } carry_type;

   // partial remainder and dividend bits turning into quotient bits
   typedef struct packed {
      logic [OPER_BITS-1:0] rem;
      logic [NUM_BITS-1:0]  nq;
   } div_type;

   typedef struct packed {
      logic [OPER_BITS-1:0] val;
      logic                 ovf;
   } sat_type;

   function automatic sat_type sat_fn(input logic signed [WIDE_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] maxv;
      logic signed [WIDE_BITS-1:0] minv;
      sat_type s;
      maxv = $signed({{(WIDE_BITS-SAT_BITS+1){1'b0}}, {(SAT_BITS-1){1'b1}}});
      minv = ~maxv;
      if (v > maxv) begin
         s.val = maxv[OPER_BITS-1:0];
         s.ovf = 1'b1;
      end else if (v < minv) begin
         s.val = minv[OPER_BITS-1:0];
         s.ovf = 1'b1;
      end else begin
         s.val = v[OPER_BITS-1:0];
         s.ovf = 1'b0;
      end
      return s;
   endfunction

endpackage

[design/fpa_front.sv]
module fpa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [fpa_pkg::MODE_BITS-1:0] mode,
   input  logic [fpa_pkg::OPER_BITS-1:0] operand_a,
   input  logic [fpa_pkg::OPER_BITS-1:0] operand_b,
   output logic                          out_valid,
   output fpa_pkg::carry_type            out_carry,
   output fpa_pkg::div_type              out_div
);
   import fpa_pkg::*;

   logic                         valid_ff;
   carry_type                    carry_ff, carry_in;
   div_type                      div_ff, div_in;
   logic signed [WIDE_BITS-1:0]  wa, wb, pick;
   logic signed [OPER_BITS-1:0]  sa, sb;
   logic signed [PROD_BITS-1:0]  prod;
   logic [OPER_BITS-1:0]         amag;
   sat_type                      s;

   assign sa = $signed(operand_a);
   assign sb = $signed(operand_b);
   assign wa = WIDE_BITS'(sa);
   assign wb = WIDE_BITS'(sb);
   assign prod = sa * sb;
   assign amag = operand_a[OPER_BITS-1] ? OPER_BITS'(-operand_a) : operand_a;

   always_comb begin
      pick = '0;
      case (mode)
         MODE_ADD: pick = wa + wb;
         MODE_SUB: pick = wa - wb;
         MODE_MIN: pick = (wa < wb) ? wa : wb;
         MODE_MAX: pick = (wa > wb) ? wa : wb;
         MODE_INC: pick = wa + ONE_W;
         MODE_DEC: pick = wa - ONE_W;
         MODE_I2F: pick = wa <<< FRAC_BITS;
         MODE_F2I: pick = wa >>> FRAC_BITS;
         default:  pick = '0;
      endcase
      s = sat_fn(pick);

      carry_in.mode    = mode;
      carry_in.pre_res = s.val;
      carry_in.pre_ovf = s.ovf;
      carry_in.lt      = sa < sb;
      carry_in.gt      = sa > sb;
      carry_in.eq      = sa == sb;
      carry_in.dz      = (mode == MODE_DIV) && (operand_b == '0);
      carry_in.prod    = prod;
      carry_in.neg     = operand_a[OPER_BITS-1] ^ operand_b[OPER_BITS-1];
      carry_in.dsr     = operand_b[OPER_BITS-1] ? OPER_BITS'(-operand_b) : operand_b;
      div_in.rem       = '0;
      div_in.nq        = {amag, {FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         carry_ff <= carry_in;
         div_ff   <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_carry = carry_ff;
   assign out_div   = div_ff;
endmodule

[design/fpa_cell.sv]
module fpa_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  fpa_pkg::carry_type in_carry,
   input  fpa_pkg::div_type   in_div,
   output logic               out_valid,
   output fpa_pkg::carry_type out_carry,
   output fpa_pkg::div_type   out_div
);
   import fpa_pkg::*;

   logic                 valid_ff;
   carry_type            carry_ff;
   div_type              div_ff, div_in;
   logic [OPER_BITS:0]   shifted;
   logic [OPER_BITS+1:0] diff;

   // one restoring step: bring down a dividend bit, try to subtract
   always_comb begin
      shifted = {in_div.rem, in_div.nq[NUM_BITS-1]};
      diff    = {1'b0, shifted} - {2'b00, in_carry.dsr};
      if (!diff[OPER_BITS+1]) begin
         div_in.rem = diff[OPER_BITS-1:0];
         div_in.nq  = {in_div.nq[NUM_BITS-2:0], 1'b1};
      end else begin
         div_in.rem = shifted[OPER_BITS-1:0];
         div_in.nq  = {in_div.nq[NUM_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         carry_ff <= in_carry;
         div_ff   <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_carry = carry_ff;
   assign out_div   = div_ff;
endmodule

[design/fpa_back.sv]
module fpa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  fpa_pkg::carry_type                in_carry,
   input  fpa_pkg::div_type                  in_div,
   input  logic                              rsp_tready,
   output logic                              adv,
   output logic                              rsp_tvalid,
   output logic [fpa_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import fpa_pkg::*;

   logic                          valid_ff;
   logic [RSP_DATA_BITS-1:0]      data_ff, data_in;
   logic [PROD_BITS-1:0]          pmag, pround;
   logic signed [WIDE_BITS-1:0]   wmul, wdiv;
   logic [NUM_BITS:0]             qr;
   logic                          rnd;
   sat_type                       smul, sdiv;
   logic [OPER_BITS-1:0]          res;
   logic                          ovf;

   assign adv = !valid_ff || rsp_tready;

   always_comb begin
      // multiply: round magnitude half away from zero
      pmag   = in_carry.prod[PROD_BITS-1] ? PROD_BITS'(-in_carry.prod) : in_carry.prod;
      pround = (pmag + HALF_LSB) >> FRAC_BITS;
      wmul   = $signed(WIDE_BITS'(pround));
      if (in_carry.neg) wmul = -wmul;
      smul   = sat_fn(wmul);

      // divide: round up when remainder is at least half the divisor
      rnd  = {in_div.rem, 1'b0} >= {1'b0, in_carry.dsr};
      qr   = {1'b0, in_div.nq} + (NUM_BITS+1)'(rnd);
      wdiv = $signed(WIDE_BITS'(qr));
      if (in_carry.neg) wdiv = -wdiv;
      sdiv = sat_fn(wdiv);

      case (in_carry.mode)
         MODE_MUL: begin
            res = smul.val;
            ovf = smul.ovf;
         end
         MODE_DIV: begin
            res = in_carry.dz ? '0 : sdiv.val;
            ovf = in_carry.dz ? 1'b0 : sdiv.ovf;
         end
         default: begin
            res = in_carry.pre_res;
            ovf = in_carry.pre_ovf;
         end
      endcase

      data_in = {{RSP_PAD_BITS{1'b0}}, ovf, in_carry.dz, in_carry.eq,
                 in_carry.gt, in_carry.lt, res};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
endmodule

[design/fixed_point_alu_top.sv]
// q24.8 fixed-point alu: one operation per beat, one result beat per request beat, in order.
// a request enters at the front stage, which does add, sub, min, max, inc, dec and the two
// conversions with saturation and starts the 32x32 multiply; the beat then walks a row of
// 40 divider cells (one quotient bit per cell), and the back stage rounds the product or the
// quotient, saturates and registers the result. throughput is one beat per cycle unless the
// result stalls. the whole row moves together, so a stalled result stops intake only
// while the output register is full and not taken.
module fixed_point_alu_top (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = operand_a [31:0], operand_b [63:32]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fpa_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // request: tuser = mode [3:0]
   input  logic [fpa_pkg::MODE_BITS-1:0]     req_tuser,
   // result: tdata = result [31:0], less, greater, equal, div_by_zero, overflow, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fpa_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import fpa_pkg::*;

   logic                adv;
   // stage 0 is the front register, stage k (k >= 1) is the output of divider cell k-1
   logic                vld   [NUM_BITS+1];
   carry_type           carry [NUM_BITS+1];
   div_type             dv    [NUM_BITS+1];

   assign req_tready = adv;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .mode      (req_tuser),
      .operand_a (req_tdata[OPER_BITS-1:0]),
      .operand_b (req_tdata[2*OPER_BITS-1:OPER_BITS]),
      .out_valid (vld[0]),
      .out_carry (carry[0]),
      .out_div   (dv[0])
   );

   // row of divider cells, each hands its beat to the next every cycle while the row advances
   for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
      fpa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (vld[k]),
         .in_carry  (carry[k]),
         .in_div    (dv[k]),
         .out_valid (vld[k+1]),
         .out_carry (carry[k+1]),
         .out_div   (dv[k+1])
      );
   end

   fpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld[NUM_BITS]),
      .in_carry   (carry[NUM_BITS]),
      .in_div     (dv[NUM_BITS]),
      .rsp_tready (rsp_tready),
      .adv        (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

[design/fpa_checker.sv]
`include "fixed_point_alu_top_macros.svh"

module fpa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fpa_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   logic [fpa_pkg::OPER_BITS-1:0] rsp_res;
   logic                          dz_bit;
   logic                          ovf_bit;

   assign rsp_res = rsp_tdata[fpa_pkg::OPER_BITS-1:0];
   assign dz_bit  = rsp_tdata[35];
   assign ovf_bit = rsp_tdata[36];

   `FPA_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")
   `FPA_ASSERT(a_one_compare, rsp_tvalid |-> $onehot(rsp_tdata[34:32]), "compare flags not one-hot")
   `FPA_ASSERT(a_dz_zero, (rsp_tvalid && dz_bit) |-> (rsp_res == '0 && !ovf_bit), "divide by zero")
   `FPA_ASSERT(a_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result changed")
endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (.*);
